// File: rtl/sne_pkg.sv
// ----------------------------------------------------------------------------
// sne_pkg
// Shared types, constants and codes of the Sobel / NMS edge classifier.
// ----------------------------------------------------------------------------
package sne_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_W      = 11;
    localparam int LINE_AW    = $clog2(MAX_WIDTH);
    localparam int MEM_AW     = LINE_AW + 1;
    localparam int SUM_W      = 22;
    localparam int ROOT_W     = SUM_W / 2;

    localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(3);
    localparam logic [DIM_W-1:0] WIDTH_MAX = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
    localparam logic [7:0]       HIGH_RST   = 8'd50;
    localparam logic [7:0]       LOW_RST    = 8'd20;

    localparam logic [13:0] RECIP_Q16  = 14'd11599;
    localparam logic [14:0] TAN_LO_Q16 = 15'd27146;
    localparam logic [17:0] TAN_HI_Q16 = 18'd158218;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_HIGH   = 2'd2;
    localparam logic [1:0] REG_LOW    = 2'd3;

    localparam logic FUNC_PIXEL = 1'b0;

    localparam logic [1:0] CLS_NONE   = 2'd0;
    localparam logic [1:0] CLS_WEAK   = 2'd1;
    localparam logic [1:0] CLS_STRONG = 2'd2;

    localparam logic [1:0] DIR_VERT      = 2'd0;
    localparam logic [1:0] DIR_DIAG_SAME = 2'd1;
    localparam logic [1:0] DIR_HORZ      = 2'd2;
    localparam logic [1:0] DIR_DIAG_OPP  = 2'd3;

    typedef struct packed {
        logic [1:0] dir;
        logic [7:0] mag;
    } t_grad;

    // [row][col], row 0 is the upper line, col 2 the newest column
    typedef t_grad [2:0][2:0] t_gwin;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [7:0]       high_thr;
        logic [7:0]       low_thr;
        logic             restart;
    } t_cfg;

endpackage

// File: rtl/sobel_nms_edge_classifier_core.sv
// ----------------------------------------------------------------------------
// sobel_nms_edge_classifier_core
// Streaming Sobel gradient, non-maximum suppression and edge classification.
// ----------------------------------------------------------------------------
// Each transfer on the input occupies the block until its pass through the
// state sequence ends, and a transfer that releases a result also waits for
// the output register to empty; flush ticks with nothing owed leave the block
// idle. The pace is set by the single-port pixel and gradient line memories,
// each read twice and written twice per pixel, and by the bit-serial square
// root. A result for pixel n appears once pixel n+2W+2 is in; flush ticks
// drain the owed results at the end of a frame. Writing the width or height
// restarts the stream and drops owed results. The line memories need no
// clearing pass: border handling masks stale entries.
module sobel_nms_edge_classifier_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_pixel,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_edge_class,
    output logic [7:0]  o_magnitude,
    output logic [1:0]  o_direction,
    output logic        o_last_of_frame,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = sne_pkg::DIM_W;
    localparam int AW = sne_pkg::LINE_AW;
    localparam int MW = sne_pkg::MEM_AW;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_RDB     = 11'b000_0000_0010,
        ST_WIN     = 11'b000_0000_0100,
        ST_GRAD    = 11'b000_0000_1000,
        ST_SQ1     = 11'b000_0001_0000,
        ST_SQ2     = 11'b000_0010_0000,
        ST_ROOT_GO = 11'b000_0100_0000,
        ST_ROOT    = 11'b000_1000_0000,
        ST_SCALE   = 11'b001_0000_0000,
        ST_GWIN    = 11'b010_0000_0000,
        ST_NMS     = 11'b100_0000_0000
    } t_state;

    sne_pkg::t_cfg w_cfg;

    t_state r_state, n_state;
    logic [DW:0]   r_pending, n_pending;
    logic [AW-1:0] r_rr, r_rc, r_pc;
    logic          r_o_valid;
    logic [1:0]    r_o_class;
    logic [7:0]    r_o_mag;
    logic [1:0]    r_o_dir;
    logic          r_o_last;

    logic [7:0]    r_pix_mem [2**MW];
    logic [7:0]    r_pix_rd;
    sne_pkg::t_grad r_grad_mem [2**MW];
    sne_pkg::t_grad r_grad_rd;

    logic [2:0][2:0][7:0] r_pwin;
    sne_pkg::t_gwin       r_gwin;

    logic [7:0]     r_pix_in;
    logic           r_emit;
    logic           r_gint;
    logic [7:0]     r_pa;
    sne_pkg::t_grad r_ga, r_gb;
    logic [9:0]     r_ax, r_ay;
    logic           r_same;
    logic [sne_pkg::SUM_W-1:0] r_sum;
    logic           r_dlo, r_dhi;
    logic [24:0]    r_prod;

    logic [DW:0]    w_lag;
    logic [DW:0]    w_pend_inc;
    logic           w_accept, w_is_pix, w_push, w_emit;
    logic [MW-1:0]  w_rd_addr;
    logic [MW-1:0]  w_addr0, w_addr1;
    logic signed [10:0] w_gx, w_gy;
    logic [10:0]    w_gx_abs, w_gy_abs;
    logic           w_root_done;
    logic [sne_pkg::ROOT_W-1:0] w_root;
    sne_pkg::t_grad w_gnew;
    logic [7:0]     w_mag_sat;
    logic           w_can_load;
    logic           w_interior;
    logic           w_last;
    logic [1:0]     w_cls, w_dir;
    logic [7:0]     w_mag;

    sne_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // stream bookkeeping
    assign w_lag      = (DW+1)'({w_cfg.width, 1'b0}) + (DW+1)'(2);
    assign w_pend_inc = r_pending + 1'b1;
    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid & o_ready;
    assign w_is_pix   = (i_func == sne_pkg::FUNC_PIXEL);
    assign w_push     = w_is_pix | (r_pending != '0);
    assign w_emit     = w_is_pix ? (w_pend_inc > w_lag) : (r_pending != '0);

    always_comb begin
        n_pending = r_pending;
        if (w_accept) begin
            if (w_is_pix) begin
                n_pending = w_emit ? r_pending : w_pend_inc;
            end else if (w_emit) begin
                n_pending = r_pending - 1'b1;
            end
        end
    end

    // line memories: entry {0,col} holds the line above, {1,col} two lines above
    assign w_addr0   = {1'b0, r_pc};
    assign w_addr1   = {1'b1, r_pc};
    assign w_rd_addr = (r_state == ST_RDB) ? w_addr1 : w_addr0;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WIN) begin
            r_pix_mem[w_addr1] <= r_pa;
        end else if (r_state == ST_GRAD) begin
            r_pix_mem[w_addr0] <= r_pix_in;
        end
        r_pix_rd <= r_pix_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_GRAD) begin
            r_grad_mem[w_addr1] <= r_ga;
        end else if (r_state == ST_GWIN) begin
            r_grad_mem[w_addr0] <= w_gnew;
        end
        r_grad_rd <= r_grad_mem[w_rd_addr];
    end

    // sobel on the pixel window
    always_comb begin
        w_gx = (11'($signed({3'b000, r_pwin[0][2]})) - 11'($signed({3'b000, r_pwin[0][0]})))
             + ((11'($signed({3'b000, r_pwin[1][2]})) - 11'($signed({3'b000, r_pwin[1][0]})))
                <<< 1)
             + (11'($signed({3'b000, r_pwin[2][2]})) - 11'($signed({3'b000, r_pwin[2][0]})));
        w_gy = 11'($signed({1'b0, 10'(r_pwin[0][0]) + 10'({r_pwin[0][1], 1'b0})
                          + 10'(r_pwin[0][2])}))
             - 11'($signed({1'b0, 10'(r_pwin[2][0]) + 10'({r_pwin[2][1], 1'b0})
                          + 10'(r_pwin[2][2])}));
        w_gx_abs = w_gx[10] ? 11'(-w_gx) : 11'(w_gx);
        w_gy_abs = w_gy[10] ? 11'(-w_gy) : 11'(w_gy);
    end

    sne_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_ROOT_GO),
        .i_value (r_sum),
        .o_root  (w_root),
        .o_done  (w_root_done)
    );

    always_comb begin
        w_mag_sat = r_prod[24] ? 8'd255 : r_prod[23:16];
        w_gnew    = '0;
        if (r_gint) begin
            w_gnew.mag = w_mag_sat;
            priority if (r_dlo) begin
                w_gnew.dir = sne_pkg::DIR_HORZ;
            end else if (r_dhi) begin
                w_gnew.dir = sne_pkg::DIR_VERT;
            end else begin
                w_gnew.dir = r_same ? sne_pkg::DIR_DIAG_SAME : sne_pkg::DIR_DIAG_OPP;
            end
        end
    end

    // result position tests
    assign w_interior = (r_rr != '0) && ((DW)'(r_rr) <= w_cfg.height - DW'(2))
                     && (r_rc != '0) && ((DW)'(r_rc) <= w_cfg.width - DW'(2));
    assign w_last     = ((DW)'(r_rr) == w_cfg.height - DW'(1))
                     && ((DW)'(r_rc) == w_cfg.width - DW'(1));
    assign w_can_load = !r_o_valid || i_ready;

    sne_nms u_nms (
        .i_win      (r_gwin),
        .i_interior (w_interior),
        .i_high_thr (w_cfg.high_thr),
        .i_low_thr  (w_cfg.low_thr),
        .o_class    (w_cls),
        .o_mag      (w_mag),
        .o_dir      (w_dir)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (w_accept && w_push) n_state = ST_RDB;
            ST_RDB:     n_state = ST_WIN;
            ST_WIN:     n_state = ST_GRAD;
            ST_GRAD:    n_state = ST_SQ1;
            ST_SQ1:     n_state = ST_SQ2;
            ST_SQ2:     n_state = ST_ROOT_GO;
            ST_ROOT_GO: n_state = ST_ROOT;
            ST_ROOT:    if (w_root_done) n_state = ST_SCALE;
            ST_SCALE:   n_state = ST_GWIN;
            ST_GWIN:    n_state = r_emit ? ST_NMS : ST_IDLE;
            ST_NMS:     if (w_can_load) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pending <= '0;
            r_rr      <= '0;
            r_rc      <= '0;
            r_pc      <= '0;
            r_o_valid <= 1'b0;
            r_pwin    <= '0;
            r_gwin    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_NMS && w_can_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_cfg.restart) begin
                r_pending <= '0;
                r_rr      <= '0;
                r_rc      <= '0;
                r_pc      <= '0;
            end else begin
                r_pending <= n_pending;
                if (r_state == ST_GWIN) begin
                    r_pc <= ((DW)'(r_pc) + DW'(1) == w_cfg.width) ? '0 : r_pc + 1'b1;
                end
                if (r_state == ST_NMS && w_can_load) begin
                    if ((DW)'(r_rc) + DW'(1) == w_cfg.width) begin
                        r_rc <= '0;
                        r_rr <= ((DW)'(r_rr) + DW'(1) == w_cfg.height) ? '0 : r_rr + 1'b1;
                    end else begin
                        r_rc <= r_rc + 1'b1;
                    end
                end
            end
            if (r_state == ST_WIN) begin
                for (int r = 0; r < 3; r++) begin
                    r_pwin[r][0] <= r_pwin[r][1];
                    r_pwin[r][1] <= r_pwin[r][2];
                end
                r_pwin[0][2] <= r_pix_rd;
                r_pwin[1][2] <= r_pa;
                r_pwin[2][2] <= r_pix_in;
            end
            if (r_state == ST_GWIN) begin
                for (int r = 0; r < 3; r++) begin
                    r_gwin[r][0] <= r_gwin[r][1];
                    r_gwin[r][1] <= r_gwin[r][2];
                end
                r_gwin[0][2] <= r_gb;
                r_gwin[1][2] <= r_ga;
                r_gwin[2][2] <= w_gnew;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix_in <= w_is_pix ? i_pixel : 8'd0;
            r_emit   <= w_emit;
            r_gint   <= w_emit && ((DW)'(r_rr) + DW'(3) <= w_cfg.height)
                               && ((DW)'(r_rc) + DW'(3) <= w_cfg.width);
        end
        if (r_state == ST_RDB) begin
            r_pa <= r_pix_rd;
            r_ga <= r_grad_rd;
        end
        if (r_state == ST_WIN) begin
            r_gb <= r_grad_rd;
        end
        if (r_state == ST_GRAD) begin
            r_ax   <= w_gx_abs[9:0];
            r_ay   <= w_gy_abs[9:0];
            r_same <= ((w_gx > 11'sd0) == (w_gy > 11'sd0));
        end
        if (r_state == ST_SQ1) begin
            r_sum <= sne_pkg::SUM_W'(r_ax * r_ax);
            r_dlo <= {r_ay, 16'b0} <= 26'(r_ax * sne_pkg::TAN_LO_Q16);
        end
        if (r_state == ST_SQ2) begin
            r_sum <= r_sum + sne_pkg::SUM_W'(r_ay * r_ay);
            r_dhi <= 28'({r_ay, 16'b0}) >= 28'(r_ax * sne_pkg::TAN_HI_Q16);
        end
        if (r_state == ST_SCALE) begin
            r_prod <= 25'(w_root * sne_pkg::RECIP_Q16);
        end
        if (r_state == ST_NMS && w_can_load) begin
            r_o_class <= w_cls;
            r_o_mag   <= w_mag;
            r_o_dir   <= w_dir;
            r_o_last  <= w_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_edge_class    = r_o_class;
    assign o_magnitude     = r_o_mag;
    assign o_direction     = r_o_dir;
    assign o_last_of_frame = r_o_last;

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= w_lag)
        else $error("owed result count above pipeline lag");

    a_position_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((DW)'(r_rc) < w_cfg.width) && ((DW)'(r_rr) < w_cfg.height)
        && ((DW)'(r_pc) < w_cfg.width))
        else $error("frame position outside geometry");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NMS && w_can_load) |=> r_o_valid)
        else $error("result not presented after suppression step");

endmodule

// File: rtl/sne_cfg_regs.sv
// ----------------------------------------------------------------------------
// sne_cfg_regs
// APB register file: frame geometry (clamped) and edge thresholds.
// ----------------------------------------------------------------------------
module sne_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output sne_pkg::t_cfg        o_cfg
);

    logic [sne_pkg::DIM_W-1:0] r_width;
    logic [sne_pkg::DIM_W-1:0] r_height;
    logic [7:0]                r_high;
    logic [7:0]                r_low;
    logic                      w_wr;
    logic [1:0]                w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sne_pkg::WIDTH_RST;
            r_height <= sne_pkg::HEIGHT_RST;
            r_high   <= sne_pkg::HIGH_RST;
            r_low    <= sne_pkg::LOW_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                sne_pkg::REG_WIDTH:  r_width  <= pwdata[sne_pkg::DIM_W-1:0];
                sne_pkg::REG_HEIGHT: r_height <= pwdata[sne_pkg::DIM_W-1:0];
                sne_pkg::REG_HIGH:   r_high   <= pwdata[7:0];
                sne_pkg::REG_LOW:    r_low    <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            sne_pkg::REG_WIDTH:  prdata = 32'(r_width);
            sne_pkg::REG_HEIGHT: prdata = 32'(r_height);
            sne_pkg::REG_HIGH:   prdata = 32'(r_high);
            sne_pkg::REG_LOW:    prdata = 32'(r_low);
        endcase
    end

    always_comb begin
        priority if (r_width < sne_pkg::DIM_MIN) begin
            o_cfg.width = sne_pkg::DIM_MIN;
        end else if (r_width > sne_pkg::WIDTH_MAX) begin
            o_cfg.width = sne_pkg::WIDTH_MAX;
        end else begin
            o_cfg.width = r_width;
        end
        priority if (r_height < sne_pkg::DIM_MIN) begin
            o_cfg.height = sne_pkg::DIM_MIN;
        end else if (r_height > sne_pkg::HEIGHT_MAX) begin
            o_cfg.height = sne_pkg::HEIGHT_MAX;
        end else begin
            o_cfg.height = r_height;
        end
        o_cfg.high_thr = r_high;
        o_cfg.low_thr  = r_low;
        o_cfg.restart  = w_wr & ((w_idx == sne_pkg::REG_WIDTH) | (w_idx == sne_pkg::REG_HEIGHT));
    end

endmodule

// File: rtl/sne_isqrt.sv
// ----------------------------------------------------------------------------
// sne_isqrt
// Iterative floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module sne_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sne_pkg::SUM_W-1:0]   i_value,
    output logic [sne_pkg::ROOT_W-1:0]  o_root,
    output logic                        o_done
);

    localparam int REM_W = sne_pkg::ROOT_W + 2;
    localparam int CNT_W = $clog2(sne_pkg::ROOT_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(sne_pkg::ROOT_W - 1);

    logic [sne_pkg::SUM_W-1:0]  r_val;
    logic [REM_W-1:0]           r_rem;
    logic [sne_pkg::ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [REM_W+1:0]           w_rem_sh;
    logic [REM_W+1:0]           w_trial;
    logic                       w_fit;

    assign w_rem_sh = {r_rem, r_val[sne_pkg::SUM_W-1 -: 2]};
    assign w_trial  = (REM_W+2)'({r_root, 2'b01});
    assign w_fit    = w_rem_sh >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[sne_pkg::SUM_W-3:0], 2'b00};
            r_rem  <= w_fit ? REM_W'(w_rem_sh - w_trial) : REM_W'(w_rem_sh);
            r_root <= {r_root[sne_pkg::ROOT_W-2:0], w_fit};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

// File: rtl/sne_nms.sv
// ----------------------------------------------------------------------------
// sne_nms
// Non-maximum suppression on the gradient window and edge classification.
// ----------------------------------------------------------------------------
module sne_nms (
    input  sne_pkg::t_gwin i_win,
    input  logic           i_interior,
    input  logic [7:0]     i_high_thr,
    input  logic [7:0]     i_low_thr,
    output logic [1:0]     o_class,
    output logic [7:0]     o_mag,
    output logic [1:0]     o_dir
);

    sne_pkg::t_grad w_ctr;
    logic [7:0]     w_n1;
    logic [7:0]     w_n2;
    logic [7:0]     w_mag;

    always_comb begin
        w_ctr = i_win[1][1];
        unique case (w_ctr.dir)
            sne_pkg::DIR_VERT: begin
                w_n1 = i_win[0][1].mag;
                w_n2 = i_win[2][1].mag;
            end
            sne_pkg::DIR_DIAG_SAME: begin
                w_n1 = i_win[0][2].mag;
                w_n2 = i_win[2][0].mag;
            end
            sne_pkg::DIR_HORZ: begin
                w_n1 = i_win[1][0].mag;
                w_n2 = i_win[1][2].mag;
            end
            sne_pkg::DIR_DIAG_OPP: begin
                w_n1 = i_win[0][0].mag;
                w_n2 = i_win[2][2].mag;
            end
        endcase
        w_mag = ((w_ctr.mag < w_n1) || (w_ctr.mag < w_n2)) ? 8'd0 : w_ctr.mag;

        if (!i_interior) begin
            o_class = sne_pkg::CLS_NONE;
            o_mag   = 8'd0;
            o_dir   = sne_pkg::DIR_VERT;
        end else begin
            o_mag = w_mag;
            o_dir = w_ctr.dir;
            priority if (w_mag < i_low_thr) begin
                o_class = sne_pkg::CLS_NONE;
            end else if (w_mag > i_high_thr) begin
                o_class = sne_pkg::CLS_STRONG;
            end else begin
                o_class = sne_pkg::CLS_WEAK;
            end
        end
    end

endmodule

// File: bench/tb_sobel_nms_edge_classifier_core.sv
// ----------------------------------------------------------------------------
// tb_sobel_nms_edge_classifier_core
// Streams whole frames of pixels through the edge classifier over the
// valid/ready channels, flushes at the end of each group of frames and
// checks every result transfer against a local model of the Sobel gradient,
// suppression and threshold classification. Geometry and thresholds are
// changed over the register port between groups, extremes included.
// ----------------------------------------------------------------------------
module tb_sobel_nms_edge_classifier_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 100;
    localparam int HIST_DEPTH  = 16384;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct {
        logic [1:0] cls;
        logic [7:0] mag;
        logic [1:0] dir;
        logic       last;
    } t_edge_res;

    typedef struct {
        logic      func;
        logic [7:0] pix;
        bit        typed;
        t_edge_res res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_func;
    logic [7:0]  i_pixel;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_edge_class;
    logic [7:0]  o_magnitude;
    logic [1:0]  o_direction;
    logic        o_last_of_frame;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sobel_nms_edge_classifier_core DUT (.*);

    // model state
    logic [7:0]  pix_hist [HIST_DEPTH];
    int unsigned wr_cnt, col_pos, row_pos, owed;
    int unsigned cfg_w, cfg_h, cfg_hi, cfg_lo;

    t_edge_res   owed_edges [$];
    int          err_cnt;
    int unsigned acc_cnt;
    int unsigned snd_idle, rcv_stall;
    bit          hold_go;
    bit          row_typed;
    t_edge_res   row_res;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_sobel_nms_edge_classifier_core NOT OK");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_cnt++;
    endtask

    function automatic int unsigned eff_w();
        return cfg_w < 3 ? 3 : (cfg_w > sne_pkg::MAX_WIDTH ? sne_pkg::MAX_WIDTH : cfg_w);
    endfunction

    function automatic int unsigned eff_h();
        return cfg_h < 3 ? 3 : (cfg_h > sne_pkg::MAX_HEIGHT ? sne_pkg::MAX_HEIGHT : cfg_h);
    endfunction

    function automatic int pix_at(input int unsigned idx);
        return int'(pix_hist[idx & (HIST_DEPTH - 1)]);
    endfunction

    function automatic int unsigned floor_sqrt(input int unsigned v);
        int unsigned res, b;
        res = 0;
        b = 32'h4000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void sobel_at(input int unsigned idx, input int r, input int c,
                                     output int unsigned mag, output logic [1:0] dir);
        int unsigned w, up, dn, ax, ay, m;
        int h, gx, gy;
        w = eff_w();
        h = int'(eff_h());
        up = idx - w;
        dn = idx + w;
        mag = 0;
        dir = sne_pkg::DIR_VERT;
        if (r < 1 || r > h - 2 || c < 1 || c > int'(w) - 2) return;
        gx = (pix_at(up + 1) - pix_at(up - 1)) + 2 * (pix_at(idx + 1) - pix_at(idx - 1))
           + (pix_at(dn + 1) - pix_at(dn - 1));
        gy = (pix_at(up - 1) + 2 * pix_at(up) + pix_at(up + 1))
           - (pix_at(dn - 1) + 2 * pix_at(dn) + pix_at(dn + 1));
        ax = gx < 0 ? -gx : gx;
        ay = gy < 0 ? -gy : gy;
        m = (floor_sqrt(ax * ax + ay * ay) * 11599) >> 16;
        mag = m > 255 ? 255 : m;
        if (longint'(ay) * 65536 <= longint'(ax) * 27146) dir = sne_pkg::DIR_HORZ;
        else if (longint'(ay) * 65536 >= longint'(ax) * 158218) dir = sne_pkg::DIR_VERT;
        else dir = ((gx > 0) == (gy > 0)) ? sne_pkg::DIR_DIAG_SAME : sne_pkg::DIR_DIAG_OPP;
    endfunction

    function automatic int unsigned nbr_mag(input int unsigned q, input int r, input int c,
                                            input int dr, input int dc);
        int unsigned idx, m;
        logic [1:0] d;
        idx = q;
        if (dr < 0) idx -= eff_w();
        if (dr > 0) idx += eff_w();
        idx = idx + dc;
        sobel_at(idx, r + dr, c + dc, m, d);
        return m;
    endfunction

    function automatic t_edge_res next_edge();
        t_edge_res res;
        int unsigned w, h, q, mag, n1, n2;
        logic [1:0] dir;
        int r, c, dr, dc;
        w = eff_w();
        h = eff_h();
        q = wr_cnt - owed;
        r = int'(row_pos);
        c = int'(col_pos);
        sobel_at(q, r, c, mag, dir);
        dr = 1;
        dc = 0;
        case (dir)
            sne_pkg::DIR_DIAG_SAME: begin dr = -1; dc = 1; end
            sne_pkg::DIR_HORZ:      begin dr = 0;  dc = 1; end
            sne_pkg::DIR_DIAG_OPP:  begin dr = 1;  dc = 1; end
            default: ;
        endcase
        n1 = nbr_mag(q, r, c, dr, dc);
        n2 = nbr_mag(q, r, c, -dr, -dc);
        if (mag < n1 || mag < n2) mag = 0;
        if (r < 1 || r > int'(h) - 2 || c < 1 || c > int'(w) - 2) res.cls = sne_pkg::CLS_NONE;
        else if (mag < cfg_lo) res.cls = sne_pkg::CLS_NONE;
        else if (mag > cfg_hi) res.cls = sne_pkg::CLS_STRONG;
        else res.cls = sne_pkg::CLS_WEAK;
        res.mag  = mag[7:0];
        res.dir  = dir;
        res.last = (row_pos == h - 1 && col_pos == w - 1);
        owed--;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        return res;
    endfunction

    function automatic bit edge_step(input logic f, input logic [7:0] p, output t_edge_res res);
        if (f == sne_pkg::FUNC_PIXEL) begin
            pix_hist[wr_cnt & (HIST_DEPTH - 1)] = p;
            wr_cnt++;
            owed++;
            if (owed > 2 * eff_w() + 2) begin
                res = next_edge();
                return 1'b1;
            end
            return 1'b0;
        end
        if (owed > 0) begin
            res = next_edge();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // transfer monitor and result check
    always @(posedge i_clk) begin
        t_edge_res res, want;
        if (i_rst_n && i_valid && o_ready) begin
            if (edge_step(i_func, i_pixel, res))
                owed_edges.push_back(row_typed ? row_res : res);
            acc_cnt++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (owed_edges.size() == 0) begin
                report("unexpected result", o_magnitude, 0);
            end else begin
                want = owed_edges.pop_front();
                if (o_edge_class !== want.cls) report("edge_class", o_edge_class, want.cls);
                if (o_magnitude !== want.mag) report("magnitude", o_magnitude, want.mag);
                if (o_direction !== want.dir) report("direction", o_direction, want.dir);
                if (o_last_of_frame !== want.last)
                    report("last_of_frame", o_last_of_frame, want.last);
            end
        end
    end

    // result side
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                i_ready = 1'b0;
                repeat (3000) @(negedge i_clk);
            end
            i_ready = ($urandom_range(99) >= rcv_stall);
        end
    end

    task automatic push_item(input logic f, input logic [7:0] p);
        int unsigned n;
        while ($urandom_range(99) < snd_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_func  = f;
        i_pixel = p;
        n = acc_cnt;
        do @(negedge i_clk); while (acc_cnt == n);
    endtask

    task automatic go_idle();
        i_valid = 1'b0;
        while (owed_edges.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input int unsigned val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            sne_pkg::REG_WIDTH: begin
                cfg_w = val & 32'h7ff; col_pos = 0; row_pos = 0; owed = 0;
            end
            sne_pkg::REG_HEIGHT: begin
                cfg_h = val & 32'h7ff; col_pos = 0; row_pos = 0; owed = 0;
            end
            sne_pkg::REG_HIGH: cfg_hi = val & 32'hff;
            default:           cfg_lo = val & 32'hff;
        endcase
    endtask

    task automatic reg_check(input logic [1:0] idx, input int unsigned want);
        logic [31:0] got;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (got !== want) report("register read", got, want);
    endtask

    function automatic logic [7:0] frame_pixel(input int style, input int unsigned r,
                                               input int unsigned c);
        case (style)
            0: return 8'($urandom_range(255));
            1: return 8'($urandom_range(15) + 100);
            2: return 8'(r * 9 + c * 5 + $urandom_range(3));
            3: return $urandom_range(1) ? 8'd255 : 8'd0;
            default: return 8'd77;
        endcase
    endfunction

    // whole frames then a drain of every owed result
    task automatic send_frames(input int n_frames, output int unsigned sent);
        int unsigned w, h, r, c;
        int style;
        w = eff_w();
        h = eff_h();
        sent = 0;
        for (int f = 0; f < n_frames; f++) begin
            style = $urandom_range(4);
            for (r = 0; r < h; r++)
                for (c = 0; c < w; c++) begin
                    push_item(sne_pkg::FUNC_PIXEL, frame_pixel(style, r, c));
                    sent++;
                end
        end
        for (int k = 0; k < 2 * w + 2 + $urandom_range(3); k++) begin
            push_item(FUNC_FLUSH, 8'($urandom_range(255)));
            sent++;
        end
    endtask

    t_stim_row dir_rows [18];

    initial begin
        int unsigned sent, total;
        err_cnt = 0;
        acc_cnt = 0;
        hold_go = 1'b0;
        row_typed = 1'b0;
        snd_idle = 0;
        rcv_stall = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = sne_pkg::FUNC_PIXEL;
        i_pixel = 8'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 4'd0;
        pwdata = 32'd0;
        foreach (pix_hist[k]) pix_hist[k] = 8'd0;
        wr_cnt = 0; col_pos = 0; row_pos = 0; owed = 0;
        cfg_w = 640; cfg_h = 480; cfg_hi = 50; cfg_lo = 20;

        // left column dark, right column bright: strong horizontal edge in the middle
        for (int k = 0; k < 9; k++)
            dir_rows[k] = '{sne_pkg::FUNC_PIXEL,
                            (k % 3 == 0) ? 8'd0 : (k % 3 == 1) ? 8'd128 : 8'd255,
                            1'b0, '{sne_pkg::CLS_NONE, 8'd0, sne_pkg::DIR_VERT, 1'b0}};
        dir_rows[8].typed = 1'b1;
        for (int k = 9; k < 17; k++)
            dir_rows[k] = '{FUNC_FLUSH, 8'd0, 1'b1,
                            '{sne_pkg::CLS_NONE, 8'd0, sne_pkg::DIR_VERT, 1'b0}};
        dir_rows[12].res = '{sne_pkg::CLS_STRONG, 8'd180, sne_pkg::DIR_HORZ, 1'b0};
        dir_rows[16].res.last = 1'b1;
        dir_rows[17] = '{FUNC_FLUSH, 8'd255, 1'b0,
                         '{sne_pkg::CLS_NONE, 8'd0, sne_pkg::DIR_VERT, 1'b0}};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        reg_check(sne_pkg::REG_WIDTH, 640);
        reg_check(sne_pkg::REG_HEIGHT, 480);
        reg_check(sne_pkg::REG_HIGH, 50);
        reg_check(sne_pkg::REG_LOW, 20);

        reg_write(sne_pkg::REG_WIDTH, 3);
        reg_write(sne_pkg::REG_HEIGHT, 3);
        foreach (dir_rows[k]) begin
            row_typed = dir_rows[k].typed;
            row_res = dir_rows[k].res;
            push_item(dir_rows[k].func, dir_rows[k].pix);
        end
        i_valid = 1'b0;
        row_typed = 1'b0;
        go_idle();

        total = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 72; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 72; end
                default: begin snd_idle = 23; rcv_stall = 23; end
            endcase
            while (total < (ph + 1) * 300) begin
                reg_write(sne_pkg::REG_WIDTH, $urandom_range(4) == 0 ? $urandom_range(2)
                                                                     : $urandom_range(3, 9));
                reg_write(sne_pkg::REG_HEIGHT, $urandom_range(3, 6));
                case ($urandom_range(3))
                    0: begin
                        reg_write(sne_pkg::REG_HIGH, 255);
                        reg_write(sne_pkg::REG_LOW, 0);
                    end
                    1: begin
                        reg_write(sne_pkg::REG_HIGH, 0);
                        reg_write(sne_pkg::REG_LOW, 255);
                    end
                    2: begin
                        reg_write(sne_pkg::REG_HIGH, $urandom_range(255));
                        reg_write(sne_pkg::REG_LOW, cfg_hi);
                    end
                    default: begin
                        reg_write(sne_pkg::REG_HIGH, $urandom_range(80));
                        reg_write(sne_pkg::REG_LOW, $urandom_range(60));
                    end
                endcase
                if (ph == 2 && total < 700) hold_go = 1'b1;
                send_frames($urandom_range(1, 3), sent);
                total += sent;
                i_valid = 1'b0;
                go_idle();
            end
        end

        // geometry extremes: raw values read back, clamped values in use
        snd_idle = 0;
        rcv_stall = 0;
        reg_write(sne_pkg::REG_WIDTH, 2047);
        reg_write(sne_pkg::REG_HEIGHT, 2047);
        reg_check(sne_pkg::REG_WIDTH, 2047);
        reg_check(sne_pkg::REG_HEIGHT, 2047);
        reg_write(sne_pkg::REG_HIGH, 40);
        reg_write(sne_pkg::REG_LOW, 10);
        reg_write(sne_pkg::REG_WIDTH, 0);
        reg_write(sne_pkg::REG_HEIGHT, 1);
        send_frames(2, sent);
        i_valid = 1'b0;
        go_idle();

        if (err_cnt == 0) begin
            $display("tb_sobel_nms_edge_classifier_core OK");
        end else begin
            $display("tb_sobel_nms_edge_classifier_core NOT OK");
        end
        $finish;
    end

endmodule
